### rtl/sbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the sorted table search block
// Table geometry, field widths, action codes, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int ACTION_W = 1;
    localparam int ENTRY_W  = 10;
    localparam int KEYIN_W  = 32;
    localparam int COUNT_W  = 11;

    localparam logic [ACTION_W-1:0] ACT_WRITE  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 1'b1;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } sbs_state_t;

    typedef struct packed {
        logic wr;            // store the incoming word in the table
        logic start;         // load bounds and key for a new search
        logic step;          // narrow bounds from the current probe
        logic rd;            // issue a table read this cycle
        logic pend_load;     // keep the finished result until output is free
        logic out_load;      // load the output register
        logic out_from_pend; // output source: held result instead of live hit
    } sbs_cmd_t;

    typedef struct packed {
        logic empty;         // effective count is zero
        logic hit;           // probed entry equals the key
        logic range_empty;   // bounds after this probe leave nothing
    } sbs_status_t;

endpackage

### rtl/sbs_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs channels: valid/ready interfaces of the sorted table search block
// Request channel (action, index, key), result channel (found) and the
// table count write channel.
// ----------------------------------------------------------------------------
interface sbs_req_if import sbs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [ENTRY_W-1:0]         entry_index;
    logic signed [KEYIN_W-1:0]  key_value;

    modport source (output valid, output action, output entry_index, output key_value,
                    input ready);
    modport sink   (input valid, input action, input entry_index, input key_value,
                    output ready);
endinterface

interface sbs_rsp_if ();
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

interface sbs_cfg_if import sbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_ram: generic simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sbs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_datapath: key table, search bounds and result registers
// Holds the table count, the key table memory, the lo/hi/mid bounds of the
// running search and the compare that narrows them each probe.
// ----------------------------------------------------------------------------
module sbs_datapath import sbs_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [COUNT_W-1:0]        cfg_data,
    input  logic [ENTRY_W-1:0]        entry_index,
    input  logic signed [KEYIN_W-1:0] key_value,
    input  sbs_cmd_t                  cmd,
    output sbs_status_t               status,
    output logic                      found
);

    logic [COUNT_W-1:0] count_reg;
    logic [CNT_W-1:0]   eff_count;

    key_t               key_in;
    key_t               key_reg;
    key_t               rd_key;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   lo_step, hi_step, span, mid_wide;
    logic [IDX_W-1:0]   mid_start, mid_step;

    logic               hit, less, idx_ok;
    logic               pend_reg;
    logic               found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    // counts above the table depth saturate
    assign eff_count = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(count_reg);

    // sign-extend or truncate the incoming key to the table width
    assign key_in = KEY_WIDTH'(key_value);
    assign idx_ok = 32'(entry_index) < 32'(TABLE_DEPTH);

    assign rd_key = ram_rdata;
    assign hit    = (rd_key == key_reg);
    assign less   = (rd_key < key_reg);

    always_comb
    begin
        lo_step   = less ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
        hi_step   = less ? hi_reg : CNT_W'(mid_reg);
        span      = hi_step - lo_step;
        mid_wide  = lo_step + (span >> 1);
        mid_step  = mid_wide[IDX_W-1:0];
        mid_start = IDX_W'(eff_count >> 1);
    end

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        if (cmd.start)
        begin
            lo_next  = '0;
            hi_next  = eff_count;
            mid_next = mid_start;
        end
        else if (cmd.step)
        begin
            lo_next  = lo_step;
            hi_next  = hi_step;
            mid_next = mid_step;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (cmd.start)
        begin
            key_reg  <= key_in;
            pend_reg <= 1'b0;
        end
        else if (cmd.pend_load)
        begin
            pend_reg <= hit;
        end
        if (cmd.out_load)
        begin
            found_reg <= cmd.out_from_pend ? pend_reg : hit;
        end
    end

    sbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_key_table (
        .clk   (clk),
        .wen   (cmd.wr & idx_ok),
        .waddr (IDX_W'(entry_index)),
        .wdata (key_in),
        .ren   (cmd.rd),
        .raddr (mid_next),
        .rdata (ram_rdata)
    );

    assign status.empty       = (eff_count == '0);
    assign status.hit         = hit;
    assign status.range_empty = (lo_step >= hi_step);
    assign found              = found_reg;

endmodule

### rtl/sbs_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_controller: search sequencer
// Accepts request words, steps the datapath one probe per cycle and hands
// finished results to the output register.
// ----------------------------------------------------------------------------
module sbs_controller import sbs_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [ACTION_W-1:0] req_action,
    output logic                req_ready,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    input  sbs_status_t         status,
    output sbs_cmd_t            cmd
);

    sbs_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       finish;

    assign out_free = !out_valid_reg || rsp_ready;
    assign finish   = status.hit || status.range_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_action == ACT_SEARCH)
                begin
                    state_next = status.empty ? ST_HOLD : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (finish)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_action == ACT_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        cmd.rd    = !status.empty;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (!finish)
                begin
                    cmd.rd = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                end
                else
                begin
                    cmd.pend_load = 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_from_pend = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

### rtl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search: membership test over a loaded sorted key table
// Software loads signed keys word by word and searches with a half-open
// binary search over the first table_count entries.
// ----------------------------------------------------------------------------
// A write word is taken and stored at once; a search word is
// taken and then probes the key table once per cycle, up to
// ceil(log2(count + 1)) probes (11 for a full table of 1024 entries), paced
// by the single read port of the key table memory and its
// registered read. An empty table answers after the accept cycle. The found
// word sits in an output register, so the next request word is taken in the
// cycle after a search finishes even while that result is unread; if the
// output register still holds an older unread word when a search finishes,
// the new result waits in a hold register and request words stall until the
// output register drains.
// table_count is written through its own channel, which is always ready.
module sorted_table_binary_search import sbs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    sbs_req_if.sink   req,
    sbs_cfg_if.sink   cfg,
    sbs_rsp_if.source rsp
);

    sbs_cmd_t    cmd;
    sbs_status_t status;

    assign cfg.ready = 1'b1;

    sbs_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .status     (status),
        .cmd        (cmd)
    );

    sbs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .entry_index (req.entry_index),
        .key_value   (req.key_value),
        .cmd         (cmd),
        .status      (status),
        .found       (rsp.found)
    );

endmodule

### test/tb_sorted_table_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search: self-checking bench of the sorted key table
// Loads sorted, unsorted and sparse tables, sweeps table_count over small and
// saturating values, and checks every found word against a mirror of the
// table and an in-bench binary search. Both channel ends stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
    import sbs_pkg::*;

    localparam int   SETTLE_CYCLES = 16;
    localparam key_t KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam key_t KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ENTRY_W-1:0]  index;
        key_t                key;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                req_valid  = 1'b0;
    logic [ACTION_W-1:0] req_action = ACT_WRITE;
    logic [ENTRY_W-1:0]  req_index  = '0;
    key_t                req_key    = '0;
    logic                cfg_valid  = 1'b0;
    logic [COUNT_W-1:0]  cfg_data   = '0;
    logic                rsp_ready  = 1'b0;

    sbs_req_if req_ch ();
    sbs_cfg_if cfg_ch ();
    sbs_rsp_if rsp_ch ();

    assign req_ch.valid       = req_valid;
    assign req_ch.action      = req_action;
    assign req_ch.entry_index = req_index;
    assign req_ch.key_value   = req_key;
    assign cfg_ch.valid       = cfg_valid;
    assign cfg_ch.data        = cfg_data;
    assign rsp_ch.ready       = rsp_ready;

    sorted_table_binary_search uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // mirror of the block state
    key_t               key_mirror [TABLE_DEPTH];
    bit                 key_written [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_mirror = '0;

    request_t req_backlog [$];
    logic     found_expected [$];
    request_t on_bus;
    logic     want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    function automatic int eff_count();
        return (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
    endfunction

    // half-open binary search over the mirror; flags probes of unwritten entries
    function automatic logic search_table(input key_t key, output logic unsafe);
        int   lo;
        int   hi;
        int   mid;
        logic hit;
        lo     = 0;
        hi     = eff_count();
        hit    = 1'b0;
        unsafe = 1'b0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (!key_written[mid])
                unsafe = 1'b1;
            if (key_mirror[mid] == key)
                hit = 1'b1;
            else if (key_mirror[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return hit;
    endfunction

    function automatic void apply_request(input request_t r);
        logic unsafe;
        logic hit_exp;
        if (r.action == ACT_WRITE) begin
            key_mirror[r.index]  = r.key;
            key_written[r.index] = 1'b1;
        end
        else begin
            hit_exp = search_table(r.key, unsafe);
            found_expected.insert(found_expected.size(), hit_exp);
        end
    endfunction

    // request driver
    always @(posedge clk) begin
        if (req_valid && req_ch.ready)
            apply_request(on_bus);
        if (!req_valid || req_ch.ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                on_bus = req_backlog.pop_front();
                req_valid  <= 1'b1;
                req_action <= on_bus.action;
                req_index  <= on_bus.index;
                req_key    <= on_bus.key;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result monitor, with a long hold-off now and then to back up the block
    always @(posedge clk) begin
        if (rsp_ready && rsp_ch.valid) begin
            if (found_expected.size() == 0) begin
                $error("found: expected no word, got %0b", rsp_ch.found);
                mismatches++;
            end
            else begin
                want = found_expected.pop_front();
                if (rsp_ch.found !== want) begin
                    $error("found: expected %0b, got %0b", want, rsp_ch.found);
                    mismatches++;
                end
            end
            results_seen++;
            if (results_seen % 250 == 100)
                hold_left = 300;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void push_write(input int idx, input key_t k);
        request_t r;
        r.action = ACT_WRITE;
        r.index  = ENTRY_W'(idx);
        r.key    = k;
        req_backlog.insert(req_backlog.size(), r);
        items_sent++;
    endfunction

    function automatic void push_search(input key_t k);
        request_t r;
        r.action = ACT_SEARCH;
        r.index  = ENTRY_W'($urandom);
        r.key    = k;
        req_backlog.insert(req_backlog.size(), r);
        items_sent++;
    endfunction

    function automatic key_t rand_key();
        if ($urandom_range(1))
            return key_t'($urandom);
        return key_t'(int'($urandom_range(64)) - 32);
    endfunction

    function automatic key_t pick_search_key();
        int   eff;
        int   sel;
        int   i;
        key_t k;
        eff = eff_count();
        sel = $urandom_range(99);
        i   = (eff != 0) ? $urandom_range(eff - 1) : 0;
        k   = key_written[i] ? key_mirror[i] : key_t'($urandom);
        if (eff != 0 && sel < 45)
            return k;
        if (eff != 0 && sel < 70)
            return $urandom_range(1) ? k + 1 : k - 1;
        if (sel < 80)
            return $urandom_range(1) ? KEY_MIN : KEY_MAX;
        return rand_key();
    endfunction

    // the minimum key only walks the left edge, which every load writes
    function automatic void queue_search();
        key_t k;
        logic unsafe;
        int   tries;
        tries = 0;
        do begin
            k = pick_search_key();
            void'(search_table(k, unsafe));
            tries++;
        end while (unsafe && tries < 40);
        push_search(unsafe ? KEY_MIN : k);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || found_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(input int c);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(c);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        count_mirror = COUNT_W'(c);
        cfg_valid <= 1'b0;
    endtask

    task automatic search_stream(input int m, input bit with_writes);
        int i;
        int sel;
        int eff;
        for (i = 0; i < m; i++) begin
            sel = $urandom_range(99);
            eff = eff_count();
            if (with_writes && sel < 8 && eff < TABLE_DEPTH)
                push_write($urandom_range(TABLE_DEPTH - 1, eff), rand_key());
            else if (with_writes && sel < 12 && eff != 0)
                push_write($urandom_range(eff - 1), rand_key());
            else
                queue_search();
        end
    endtask

    task automatic directed_checks();
        set_count(0);
        push_search(KEY_MIN);
        push_search(KEY_MAX);
        push_search('0);
        push_write(0, KEY_MIN);
        push_write(1, key_t'(-1000));
        push_write(2, key_t'(-1));
        push_write(3, '0);
        push_write(4, '0);
        push_write(5, key_t'(5));
        push_write(6, key_t'(1000000));
        push_write(7, KEY_MAX);
        push_write(TABLE_DEPTH - 1, rand_key());
        set_count(8);
        push_search(KEY_MIN);
        push_search(KEY_MAX);
        push_search('0);
        push_search(key_t'(5));
        push_search(key_t'(-1000));
        push_search(key_t'(1000000));
        push_search(key_t'(4));
        push_search(KEY_MIN + 1);
        push_search(KEY_MAX - 1);
        push_search(key_t'(-1));
        set_count(1);
        push_search(KEY_MIN);
        push_search(KEY_MAX);
    endtask

    task automatic load_sorted(input int n, input bit narrow);
        longint v;
        longint step_max;
        key_t   vals [$];
        int     i;
        bit     down;
        if (narrow) begin
            v        = longint'(key_t'($urandom));
            step_max = 3;
        end
        else begin
            v        = longint'(KEY_MIN);
            if ($urandom_range(3) != 0)
                v += $urandom_range(1 << 20);
            step_max = (longint'(1) << 32) / (n + 1);
        end
        for (i = 0; i < n; i++) begin
            if (v > longint'(KEY_MAX))
                v = longint'(KEY_MAX);
            vals.insert(vals.size(), key_t'(v));
            v += $urandom_range(32'(step_max));
        end
        down = $urandom_range(1);
        for (i = 0; i < n; i++)
            if (down)
                push_write(n - 1 - i, vals[n - 1 - i]);
            else
                push_write(i, vals[i]);
    endtask

    task automatic sorted_phase();
        int n;
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            n = $urandom_range(24, 1);
        else if (sel < 95)
            n = $urandom_range(128, 25);
        else
            n = $urandom_range(300, 129);
        load_sorted(n, $urandom_range(1));
        set_count(($urandom_range(3) == 0) ? $urandom_range(n) : n);
        search_stream($urandom_range(50, 20), 1'b1);
    endtask

    task automatic unsorted_phase();
        int n;
        int i;
        n = $urandom_range(32, 1);
        for (i = 0; i < n; i++)
            push_write(i, rand_key());
        set_count(n);
        search_stream($urandom_range(40, 20), 1'b1);
    endtask

    // increasing with the index, so any subset of entries stays sorted
    function automatic key_t spread_key(input int idx);
        if (idx == 0)
            return KEY_MIN;
        if (idx == TABLE_DEPTH - 1)
            return KEY_MAX;
        return key_t'(longint'(KEY_MIN) + longint'(idx) * 4194304
                      + $urandom_range(4194303));
    endfunction

    // sparse table: only both edges of the probe tree plus a few more entries
    task automatic sparse_phase(input int c);
        int eff;
        int lo;
        int hi;
        int mid;
        int i;
        set_count(c);
        eff = eff_count();
        lo  = 0;
        hi  = eff;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            push_write(mid, spread_key(mid));
            hi = mid;
        end
        lo = 0;
        hi = eff;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            push_write(mid, spread_key(mid));
            lo = mid + 1;
        end
        for (i = 0; i < 24 && eff != 0; i++) begin
            mid = $urandom_range(eff - 1);
            push_write(mid, spread_key(mid));
        end
        wait_idle();
        search_stream(30, 1'b0);
    endtask

    initial begin
        int round;
        int kind;
        int drain;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (round = 0; round < 3; round++) begin
            send_idle_pct = (round == 0) ? 32 : (round == 1) ? 67 : 0;
            recv_idle_pct = (round == 0) ? 67 : (round == 1) ? 32 : 0;
            if (round == 0)
                directed_checks();
            sparse_phase((round == 0) ? TABLE_DEPTH : (round == 1) ? 2047 : TABLE_DEPTH + 1);
            while (items_sent < (round + 1) * 450) begin
                kind = $urandom_range(9);
                if (kind == 0)
                    sparse_phase($urandom_range(1) ? TABLE_DEPTH - 1 : $urandom_range(2047, 1));
                else if (kind <= 2)
                    unsorted_phase();
                else
                    sorted_phase();
            end
        end
        drain = 0;
        @(negedge clk);
        while ((req_valid || req_backlog.size() != 0 || found_expected.size() != 0)
               && drain < 20000) begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (found_expected.size() != 0)
            $error("found: %0d expected words never arrived", found_expected.size());
        if (mismatches == 0 && found_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
